/* rtl/core/sfcd_pkg.sv */
// Shared constants and types for the sync-byte frame deframer.
`timescale 1ns / 1ps

package sfcd_pkg;

  localparam int MAX_FRAME_DEF = 64;
  localparam int MIN_FRAME = 3;
  localparam logic [7:0] HEADER_BYTE = 8'd19;
  localparam logic [6:0] FRAME_LEN_RESET = 7'd3;

  // APB register map: one 32-bit register per word
  localparam int ADDR_W = 3;
  localparam logic REG_FRAME_LENGTH = 1'b0;

  typedef enum logic [1:0] {
    ST_HUNT,
    ST_COLLECT,
    ST_DRAIN
  } st_t;

endpackage

/* rtl/core/sfcd_store.sv */
// Frame byte store: one write port, one registered read port.
`timescale 1ns / 1ps

module sfcd_store
  import sfcd_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF,
  localparam int AW = $clog2(MAX_FRAME)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [MAX_FRAME];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/sfcd_ctrl.sv */
// Header hunt, frame collection with running sum, and release of a valid frame.
`timescale 1ns / 1ps

module sfcd_ctrl
  import sfcd_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF,
  localparam int AW = $clog2(MAX_FRAME),
  localparam int CW = $clog2(MAX_FRAME + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [6:0]    frame_length,
  input  logic          rx_valid,
  output logic          rx_stall,
  input  logic [7:0]    rx_byte,
  output logic          frame_valid,
  input  logic          frame_stall,
  output logic [7:0]    frame_byte,
  output logic [5:0]    byte_position,
  output logic          last_of_frame,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output logic [7:0]    mem_wdata,
  output logic          mem_re,
  output logic [AW-1:0] mem_raddr,
  input  logic [7:0]    mem_rdata
);

  localparam int LW = (CW > 7) ? CW : 7;

  st_t           state, state_next;
  logic [CW-1:0] fill, fill_next;
  logic [7:0]    sum, sum_next;
  logic [CW-1:0] n, n_next;
  logic [CW-1:0] rd_k, rd_k_next;
  logic [CW-1:0] pend_k;
  logic          rd_pend;
  logic          in_acc, out_load;
  logic [LW-1:0] len_raw, eff_len;
  logic [CW-1:0] fill_inc;
  logic [7:0]    sum_inc;

  // frame length saturated to the legal range
  assign len_raw = LW'(frame_length);
  assign eff_len = (len_raw < LW'(MIN_FRAME)) ? LW'(MIN_FRAME) :
                   (len_raw > LW'(MAX_FRAME)) ? LW'(MAX_FRAME) : len_raw;

  assign rx_stall = (state == ST_DRAIN);
  assign in_acc   = rx_valid && !rx_stall;
  assign out_load = rd_pend && (!frame_valid || !frame_stall);
  assign mem_re   = (state == ST_DRAIN) && (rd_k < n) && (!rd_pend || out_load);
  assign mem_raddr = rd_k[AW-1:0];
  assign fill_inc = fill + CW'(1);
  assign sum_inc  = sum + rx_byte;

  always_comb begin
    state_next = state;
    fill_next  = fill;
    sum_next   = sum;
    n_next     = n;
    rd_k_next  = rd_k;
    mem_we     = 1'b0;
    mem_waddr  = fill[AW-1:0];
    mem_wdata  = rx_byte;
    case (state)
      ST_HUNT: begin
        if (in_acc && rx_byte == HEADER_BYTE) begin
          mem_we     = 1'b1;
          mem_waddr  = '0;
          fill_next  = CW'(1);
          sum_next   = rx_byte;
          state_next = ST_COLLECT;
        end
      end
      ST_COLLECT: begin
        if (in_acc) begin
          mem_we    = (fill < CW'(MAX_FRAME));
          fill_next = mem_we ? fill_inc : fill;
          sum_next  = sum_inc;
          if (LW'(fill_next) >= eff_len) begin
            n_next     = fill_next;
            rd_k_next  = '0;
            state_next = (sum_inc == 8'd0) ? ST_DRAIN : ST_HUNT;
          end
        end
      end
      ST_DRAIN: begin
        if (mem_re) begin
          rd_k_next = rd_k + CW'(1);
        end
        if (rd_k == n && !rd_pend) begin
          state_next = ST_HUNT;
        end
      end
      default: begin
        state_next = ST_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HUNT;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill        <= '0;
      sum         <= '0;
      rd_pend     <= 1'b0;
      frame_valid <= 1'b0;
    end else begin
      fill        <= fill_next;
      sum         <= sum_next;
      rd_pend     <= mem_re || (rd_pend && !out_load);
      frame_valid <= out_load || (frame_valid && frame_stall);
    end
  end

  always_ff @(posedge clk) begin
    n    <= n_next;
    rd_k <= rd_k_next;
    if (mem_re) begin
      pend_k <= rd_k;
    end
    if (out_load) begin
      frame_byte    <= mem_rdata;
      byte_position <= 6'(pend_k);
      last_of_frame <= ((pend_k + CW'(1)) == n);
    end
  end

endmodule

/* rtl/core/sync_frame_checksum_deframer_top.sv */
// Top level of the sync-byte frame deframer with additive checksum.
`timescale 1ns / 1ps

// Takes one received byte per cycle while hunting for the header byte 19
// and while collecting a frame of frame_length bytes (saturated to 3 ..
// MAX_FRAME) into an internal byte store. A frame whose bytes sum to zero
// modulo 256 is released header first, one byte per cycle unless
// frame_stall holds it back, from the store's single read port, the last
// byte flagged; rx_stall is high while the frame is read out of the store,
// also while frame_stall holds the read-out back. Frames with a bad sum
// are dropped without output. frame_length sits at APB byte address 0.

module sync_frame_checksum_deframer_top
  import sfcd_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              rx_valid,
  output logic              rx_stall,
  input  logic [7:0]        rx_byte,
  output logic              frame_valid,
  input  logic              frame_stall,
  output logic [7:0]        frame_byte,
  output logic [5:0]        byte_position,
  output logic              last_of_frame
);

  localparam int AW = $clog2(MAX_FRAME);

  logic [6:0]    frame_length;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length <= FRAME_LEN_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_FRAME_LENGTH) begin
      frame_length <= pwdata[6:0];
    end
  end

  assign prdata = (paddr[2] == REG_FRAME_LENGTH) ? {25'd0, frame_length} : 32'd0;

  sfcd_ctrl #(
    .MAX_FRAME(MAX_FRAME)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .frame_length (frame_length),
    .rx_valid     (rx_valid),
    .rx_stall     (rx_stall),
    .rx_byte      (rx_byte),
    .frame_valid  (frame_valid),
    .frame_stall  (frame_stall),
    .frame_byte   (frame_byte),
    .byte_position(byte_position),
    .last_of_frame(last_of_frame),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

  sfcd_store #(
    .MAX_FRAME(MAX_FRAME)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

endmodule
